// File: rtl/login_name_line_editor_defines.svh
// assertion macros used by the checker
`ifndef LOGIN_NAME_LINE_EDITOR_DEFINES_SVH
`define LOGIN_NAME_LINE_EDITOR_DEFINES_SVH

// same-cycle implication
`define LNLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnle assertion failed");

// next-cycle implication
`define LNLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnle assertion failed");

`endif

// File: rtl/lnle_pkg.sv
`default_nettype none
package lnle_pkg;

  localparam int unsigned InByteW  = 8;
  localparam int unsigned CharW    = 8;
  localparam int unsigned KindW    = 3;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [6:0] CH_NUL  = 7'h00;
  localparam logic [6:0] CH_EOT  = 7'h04;
  localparam logic [6:0] CH_BS   = 7'h08;
  localparam logic [6:0] CH_LF   = 7'h0a;
  localparam logic [6:0] CH_CR   = 7'h0d;
  localparam logic [6:0] CH_KILL = 7'h15;
  localparam logic [6:0] CH_SP   = 7'h20;
  localparam logic [6:0] CH_US   = 7'h5f;
  localparam logic [6:0] CASE_OFFSET = 7'h20;

  typedef enum logic [KindW-1:0] {
    KIND_ECHO    = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_RESTART = 3'd3,
    KIND_DISC    = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PARITY = 2'd0,
    CFG_FAST   = 2'd1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_NUL, ST_EOT, ST_END0, ST_END1, ST_END2, ST_DONE,
    ST_STORE, ST_BS0, ST_BS1, ST_BS2, ST_K0, ST_K1, ST_KB1, ST_KB2, ST_KB3,
    ST_KEND, ST_KS0, ST_KS1
  } step_e;

  typedef enum logic [2:0] {
    CHR_ZERO, CHR_IN, CHR_SP, CHR_BS, CHR_LF, CHR_CR, CHR_NAME
  } chr_e;

  typedef enum logic [1:0] {
    LAST_NO, LAST_YES, LAST_COND, LAST_NCOND
  } last_e;

  typedef enum logic [2:0] {
    COND_NEVER, COND_CNT_ZERO, COND_MORE, COND_BS_SHORT, COND_KILL_NONE, COND_SLOW
  } cond_e;

  typedef enum logic [1:0] {
    SEQ_BRANCH, SEQ_HOLD, SEQ_MAP
  } seq_e;

  typedef enum logic [1:0] {
    CNT_KEEP, CNT_CLR, CNT_INC, CNT_DEC
  } cnt_e;

  typedef enum logic [1:0] {
    FLG_KEEP, FLG_CLR, FLG_SET
  } flg_e;

  typedef enum logic [1:0] {
    IDX_KEEP, IDX_CLR, IDX_INC
  } idx_e;

  typedef struct packed {
    logic  emit;
    kind_e kind;
    chr_e  chr;
    last_e last;
    cond_e cond;
    seq_e  seq;
    step_e jmp;
    step_e nxt;
    cnt_e  cnt;
    flg_e  flg;
    idx_e  idx;
    logic  wr;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    emit: 1'b0, kind: KIND_ECHO, chr: CHR_ZERO, last: LAST_NO, cond: COND_NEVER,
    seq: SEQ_BRANCH, jmp: ST_IDLE, nxt: ST_IDLE, cnt: CNT_KEEP, flg: FLG_KEEP,
    idx: IDX_KEEP, wr: 1'b0
  };

endpackage
`default_nettype wire

// File: rtl/lnle_if.sv
`default_nettype none
interface lnle_in_if import lnle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [InByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lnle_out_if import lnle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] out_kind;
  logic [CharW-1:0] out_char;
  logic             out_last;
  logic             ended_by_cr;
  logic             saw_upper;
  logic             saw_lower;
  logic [LenW-1:0]  name_length;

  modport source (output valid, output out_kind, output out_char, output out_last,
                  output ended_by_cr, output saw_upper, output saw_lower,
                  output name_length, input ready);
  modport sink (input valid, input out_kind, input out_char, input out_last,
                input ended_by_cr, input saw_upper, input saw_lower,
                input name_length, output ready);
endinterface

interface lnle_cfg_if import lnle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/login_name_line_editor.sv
// order: the input byte is latched, decoded in the dispatch step, then each result is
//   registered in the output register; stored name characters also pass the store read
// throughput: a new byte is taken only once the sequencer is back in idle; the sequencer
//   issues at most one result per step, and an emitting step holds while a result stalls
// reset: sequencer idle, name count and case flags cleared, parity off, fast line on;
//   the name store is not cleared
`default_nettype none
module login_name_line_editor import lnle_pkg::*; #(
  parameter int unsigned NAME_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lnle_in_if.sink    in_i,
  lnle_out_if.source out_o,
  lnle_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

  step_e            pc_q, pc_d, map_tgt;
  ucode_t           uc;
  logic [6:0]       c_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             upper_q, upper_d, lower_q, lower_d;
  logic             parity_q, fast_q;
  logic             in_fire, step_go, cond_hit, last_bit;
  logic             cnt_zero, more, full;
  logic             is_upper, is_lower, fold;
  logic [6:0]       rdata, name_ch, raw_ch, store_ch;
  logic [CntW+3:0]  len_ext;

  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q, out_cr_q, out_up_q, out_lo_q;
  logic [LenW-1:0]  out_len_q;

  lnle_ucode_rom u_rom (
    .step_i (pc_q),
    .uc_o   (uc)
  );

  lnle_name_ram #(
    .Depth (NAME_DEPTH),
    .AddrW (CntW),
    .DataW (7)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (step_go && uc.wr),
    .waddr_i (count_q),
    .wdata_i (store_ch),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign in_i.ready  = (pc_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      c_q <= in_i.in_byte[6:0];
    end
  end

  assign cnt_zero = (count_q == '0);
  assign more     = ({1'b0, idx_q} + (CntW+1)'(1)) < {1'b0, count_q};
  assign full     = (count_q == CntW'(NAME_DEPTH - 1));
  assign is_upper = (c_q >= 7'h41) && (c_q <= 7'h5a);
  assign is_lower = (c_q >= 7'h61) && (c_q <= 7'h7a);
  assign fold     = upper_q && !lower_q;
  assign store_ch = (c_q == CH_SP) ? CH_US : c_q;
  assign name_ch  = (fold && rdata >= 7'h41 && rdata <= 7'h5a) ? rdata + CASE_OFFSET : rdata;
  assign len_ext  = {4'b0000, count_q};

  always_comb begin
    unique case (uc.cond)
      COND_CNT_ZERO:  cond_hit = cnt_zero;
      COND_MORE:      cond_hit = more;
      COND_BS_SHORT:  cond_hit = cnt_zero || !fast_q;
      COND_KILL_NONE: cond_hit = fast_q && cnt_zero;
      COND_SLOW:      cond_hit = !fast_q;
      default:        cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    priority if (c_q == CH_NUL) begin
      map_tgt = ST_NUL;
    end else if (c_q == CH_EOT) begin
      map_tgt = ST_EOT;
    end else if (c_q == CH_CR || c_q == CH_LF || full) begin
      map_tgt = ST_END0;
    end else if (c_q == CH_BS) begin
      map_tgt = ST_BS0;
    end else if (c_q == CH_KILL) begin
      map_tgt = ST_K0;
    end else begin
      map_tgt = ST_STORE;
    end
  end

  assign step_go = !uc.emit || !out_valid_q || out_o.ready;

  always_comb begin
    pc_d    = pc_q;
    count_d = count_q;
    idx_d   = idx_q;
    upper_d = upper_q;
    lower_d = lower_q;
    if (step_go) begin
      unique case (uc.seq)
        SEQ_HOLD:   pc_d = in_fire ? uc.nxt : pc_q;
        SEQ_MAP:    pc_d = map_tgt;
        SEQ_BRANCH: pc_d = cond_hit ? uc.jmp : uc.nxt;
        default:    pc_d = ST_IDLE;
      endcase
      unique case (uc.cnt)
        CNT_CLR: count_d = '0;
        CNT_INC: count_d = count_q + CntW'(1);
        CNT_DEC: count_d = cnt_zero ? count_q : count_q - CntW'(1);
        default: count_d = count_q;
      endcase
      unique case (uc.idx)
        IDX_CLR: idx_d = '0;
        IDX_INC: idx_d = idx_q + CntW'(1);
        default: idx_d = idx_q;
      endcase
      unique case (uc.flg)
        FLG_CLR: begin
          upper_d = 1'b0;
          lower_d = 1'b0;
        end
        FLG_SET: begin
          upper_d = upper_q || is_upper;
          lower_d = lower_q || is_lower;
        end
        default: begin
          upper_d = upper_q;
          lower_d = lower_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (uc.chr)
      CHR_IN:   raw_ch = c_q;
      CHR_SP:   raw_ch = CH_SP;
      CHR_BS:   raw_ch = CH_BS;
      CHR_LF:   raw_ch = CH_LF;
      CHR_CR:   raw_ch = CH_CR;
      CHR_NAME: raw_ch = name_ch;
      default:  raw_ch = '0;
    endcase
  end

  always_comb begin
    unique case (uc.last)
      LAST_YES:   last_bit = 1'b1;
      LAST_COND:  last_bit = cond_hit;
      LAST_NCOND: last_bit = !cond_hit;
      default:    last_bit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      upper_q  <= 1'b0;
      lower_q  <= 1'b0;
      parity_q <= 1'b0;
      fast_q   <= 1'b1;
    end else begin
      pc_q    <= pc_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      upper_q <= upper_d;
      lower_q <= lower_d;
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_PARITY: parity_q <= cfg_i.data[0];
          CFG_FAST:   fast_q   <= cfg_i.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && uc.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step_go && uc.emit) begin
      out_kind_q <= uc.kind;
      out_char_q <= (uc.kind == KIND_ECHO) ? {parity_q & (^raw_ch), raw_ch} : {1'b0, raw_ch};
      out_last_q <= last_bit;
      if (uc.kind == KIND_DONE) begin
        out_cr_q  <= (c_q == CH_CR);
        out_up_q  <= upper_q;
        out_lo_q  <= lower_q;
        out_len_q <= len_ext[LenW-1:0];
      end else begin
        out_cr_q  <= 1'b0;
        out_up_q  <= 1'b0;
        out_lo_q  <= 1'b0;
        out_len_q <= '0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_kind    = out_kind_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.out_last    = out_last_q;
  assign out_o.ended_by_cr = out_cr_q;
  assign out_o.saw_upper   = out_up_q;
  assign out_o.saw_lower   = out_lo_q;
  assign out_o.name_length = out_len_q;

endmodule
`default_nettype wire

// File: rtl/lnle_name_ram.sv
`default_nettype none
module lnle_name_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/lnle_ucode_rom.sv
`default_nettype none
module lnle_ucode_rom import lnle_pkg::*; (
  input  step_e  step_i,
  output ucode_t uc_o
);

  always_comb begin
    uc_o = UC_NOP;
    unique case (step_i)
      ST_IDLE: begin
        uc_o.seq = SEQ_HOLD;
        uc_o.nxt = ST_DISP;
      end
      ST_DISP: begin
        uc_o.seq = SEQ_MAP;
      end
      ST_NUL: begin
        uc_o.emit = 1'b1;
        uc_o.kind = KIND_RESTART;
        uc_o.last = LAST_YES;
        uc_o.cnt  = CNT_CLR;
        uc_o.flg  = FLG_CLR;
      end
      ST_EOT: begin
        uc_o.emit = 1'b1;
        uc_o.kind = KIND_DISC;
        uc_o.last = LAST_YES;
        uc_o.cnt  = CNT_CLR;
        uc_o.flg  = FLG_CLR;
      end
      ST_END0: begin
        uc_o.idx  = IDX_CLR;
        uc_o.cond = COND_CNT_ZERO;
        uc_o.jmp  = ST_DONE;
        uc_o.nxt  = ST_END1;
      end
      ST_END1: begin
        uc_o.nxt = ST_END2;
      end
      ST_END2: begin
        uc_o.emit = 1'b1;
        uc_o.kind = KIND_NAME;
        uc_o.chr  = CHR_NAME;
        uc_o.idx  = IDX_INC;
        uc_o.cond = COND_MORE;
        uc_o.jmp  = ST_END1;
        uc_o.nxt  = ST_DONE;
      end
      ST_DONE: begin
        uc_o.emit = 1'b1;
        uc_o.kind = KIND_DONE;
        uc_o.last = LAST_YES;
        uc_o.cnt  = CNT_CLR;
        uc_o.flg  = FLG_CLR;
      end
      ST_STORE: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_IN;
        uc_o.last = LAST_YES;
        uc_o.cnt  = CNT_INC;
        uc_o.flg  = FLG_SET;
        uc_o.wr   = 1'b1;
      end
      ST_BS0: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_IN;
        uc_o.last = LAST_COND;
        uc_o.cond = COND_BS_SHORT;
        uc_o.jmp  = ST_IDLE;
        uc_o.nxt  = ST_BS1;
        uc_o.cnt  = CNT_DEC;
      end
      ST_BS1: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_SP;
        uc_o.nxt  = ST_BS2;
      end
      ST_BS2: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_BS;
        uc_o.last = LAST_YES;
      end
      ST_K0: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_IN;
        uc_o.last = LAST_COND;
        uc_o.cond = COND_KILL_NONE;
        uc_o.jmp  = ST_IDLE;
        uc_o.nxt  = ST_K1;
      end
      ST_K1: begin
        uc_o.idx  = IDX_CLR;
        uc_o.cond = COND_SLOW;
        uc_o.jmp  = ST_KS0;
        uc_o.nxt  = ST_KB1;
      end
      ST_KB1: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_BS;
        uc_o.nxt  = ST_KB2;
      end
      ST_KB2: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_SP;
        uc_o.nxt  = ST_KB3;
      end
      ST_KB3: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_BS;
        uc_o.last = LAST_NCOND;
        uc_o.idx  = IDX_INC;
        uc_o.cond = COND_MORE;
        uc_o.jmp  = ST_KB1;
        uc_o.nxt  = ST_KEND;
      end
      ST_KEND: begin
        uc_o.cnt = CNT_CLR;
      end
      ST_KS0: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_LF;
        uc_o.nxt  = ST_KS1;
      end
      ST_KS1: begin
        uc_o.emit = 1'b1;
        uc_o.chr  = CHR_CR;
        uc_o.last = LAST_YES;
        uc_o.cnt  = CNT_CLR;
      end
      default: begin
        uc_o = UC_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/lnle_checker.sv
`default_nettype none
`include "login_name_line_editor_defines.svh"
module lnle_checker import lnle_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [KindW-1:0] out_kind_i,
  input wire logic [CharW-1:0] out_char_i,
  input wire logic             out_last_i,
  input wire logic             ended_by_cr_i,
  input wire logic             saw_upper_i,
  input wire logic             saw_lower_i,
  input wire logic [LenW-1:0]  name_length_i
);

  // a stalled result holds
  `LNLE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_char_i) && $stable(out_last_i))

  // one byte at a time
  `LNLE_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // done, restart and disconnect close the byte's results
  `LNLE_ASSERT_SAME(a_term_last, clk_i, rst_ni, out_valid_i && (out_kind_i == KIND_DONE || out_kind_i == KIND_RESTART || out_kind_i == KIND_DISC), out_last_i)

  // line flags only on the done marker
  `LNLE_ASSERT_SAME(a_flags_done, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_DONE, !ended_by_cr_i && !saw_upper_i && !saw_lower_i && name_length_i == '0)

endmodule

bind login_name_line_editor lnle_checker u_lnle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_kind_i    (out_o.out_kind),
  .out_char_i    (out_o.out_char),
  .out_last_i    (out_o.out_last),
  .ended_by_cr_i (out_o.ended_by_cr),
  .saw_upper_i   (out_o.saw_upper),
  .saw_lower_i   (out_o.saw_lower),
  .name_length_i (out_o.name_length)
);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
module tb import lnle_pkg::*; ();

  localparam int unsigned Depth = 16;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned LineItems = 28;

  typedef struct {
    kind_e            kind;
    logic [CharW-1:0] ch;
    logic             last;
    logic             cr;
    logic             up;
    logic             lo;
    logic [LenW-1:0]  len;
  } result_t;

  class name_editor_sb;
    result_t     expected_out[$];
    logic [6:0]  name_mem[Depth];
    int unsigned name_cnt;
    bit          upper_flag;
    bit          lower_flag;
    bit          parity_on;
    bit          fast_on;
    int unsigned errors;

    function new();
      name_cnt = 0;
      upper_flag = 1'b0;
      lower_flag = 1'b0;
      parity_on = 1'b0;
      fast_on = 1'b1;
      errors = 0;
      foreach (name_mem[i]) name_mem[i] = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_PARITY: parity_on = data[0];
        CFG_FAST:   fast_on = data[0];
        default: ;
      endcase
    endfunction

    function void push(kind_e kind, logic [7:0] ch, bit cr, bit up, bit lo,
                       logic [3:0] len);
      result_t r;
      r.kind = kind;
      r.ch = ch;
      r.last = 1'b0;
      r.cr = cr;
      r.up = up;
      r.lo = lo;
      r.len = len;
      expected_out.push_back(r);
    endfunction

    // even parity in bit 7 when enabled
    function void push_echo(logic [6:0] c);
      push(KIND_ECHO, {parity_on & (^c), c}, 1'b0, 1'b0, 1'b0, 4'd0);
    endfunction

    function void clear_line();
      name_cnt = 0;
      upper_flag = 1'b0;
      lower_flag = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [6:0] c;
      logic [6:0] st;
      logic [6:0] ch;
      bit         fold;
      bit         store_it;
      c = b[6:0];
      st = c;
      store_it = 1'b1;
      if (c == CH_NUL) begin
        push(KIND_RESTART, 8'h00, 1'b0, 1'b0, 1'b0, 4'd0);
        clear_line();
      end else if (c == CH_EOT) begin
        push(KIND_DISC, 8'h00, 1'b0, 1'b0, 1'b0, 4'd0);
        clear_line();
      end else if (c == CH_CR || c == CH_LF || name_cnt >= Depth - 1) begin
        fold = upper_flag && !lower_flag;
        for (int i = 0; i < name_cnt; i++) begin
          ch = name_mem[i];
          if (fold && ch >= "A" && ch <= "Z") ch = ch + CASE_OFFSET;
          push(KIND_NAME, {1'b0, ch}, 1'b0, 1'b0, 1'b0, 4'd0);
        end
        push(KIND_DONE, 8'h00, c == CH_CR, upper_flag, lower_flag, 4'(name_cnt));
        clear_line();
      end else begin
        push_echo(c);
        if (c >= "a" && c <= "z") begin
          lower_flag = 1'b1;
        end else if (c >= "A" && c <= "Z") begin
          upper_flag = 1'b1;
        end else if (c == CH_BS) begin
          store_it = 1'b0;
          if (name_cnt > 0) begin
            name_cnt--;
            if (fast_on) begin
              push_echo(CH_SP);
              push_echo(CH_BS);
            end
          end
        end else if (c == CH_KILL) begin
          store_it = 1'b0;
          if (fast_on) begin
            for (int i = 0; i < name_cnt; i++) begin
              push_echo(CH_BS);
              push_echo(CH_SP);
              push_echo(CH_BS);
            end
          end else begin
            push_echo(CH_LF);
            push_echo(CH_CR);
          end
          name_cnt = 0;
        end else if (c == CH_SP) begin
          st = CH_US;
        end
        if (store_it && name_cnt < Depth) begin
          name_mem[name_cnt] = st;
          name_cnt++;
        end
      end
      expected_out[expected_out.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected result kind %0d char %02h", got.kind, got.ch));
      end else begin
        want = expected_out.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.last !== want.last ||
            got.cr !== want.cr || got.up !== want.up || got.lo !== want.lo ||
            got.len !== want.len) begin
          report($sformatf({"got kind %0d char %02h last %0b cr %0b up %0b lo %0b len %0d,",
                            " want kind %0d char %02h last %0b cr %0b up %0b lo %0b len %0d"},
                           got.kind, got.ch, got.last, got.cr, got.up, got.lo, got.len,
                           want.kind, want.ch, want.last, want.cr, want.up, want.lo,
                           want.len));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lnle_in_if  in_if ();
  lnle_out_if out_if ();
  lnle_cfg_if cfg_if ();

  login_name_line_editor #(
    .NAME_DEPTH(Depth)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  name_editor_sb sb;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.kind = kind_e'(out_if.out_kind);
        got.ch = out_if.out_char;
        got.last = out_if.out_last;
        got.cr = out_if.ended_by_cr;
        got.up = out_if.saw_upper;
        got.lo = out_if.saw_lower;
        got.len = out_if.name_length;
        sb.check_result(got);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchLimit) begin
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input bit parity, input bit fast);
    logic [CfgDataW-1:0] data;
    cfg_idx_e            idx;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? CFG_PARITY : CFG_FAST;
      data = {7'($urandom_range(127)), (i == 0) ? parity : fast};
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data <= data;
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      sb.set_reg(idx, data);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    int         r;
    logic [6:0] c;
    r = $urandom_range(99);
    if (r >= 90) return 8'($urandom_range(255));
    if (r < 35) c = 7'($urandom_range(8'h7a, 8'h61));
    else if (r < 60) c = 7'($urandom_range(8'h5a, 8'h41));
    else if (r < 70) c = CH_SP;
    else if (r < 78) c = CH_BS;
    else if (r < 81) c = CH_KILL;
    else c = 7'($urandom_range(8'h7e, 8'h21));
    return {1'($urandom_range(1)), c};
  endfunction

  // a login line with random content, mostly well formed
  task automatic send_line();
    int         n;
    int         r;
    logic [6:0] term;
    if ($urandom_range(99) < 10) send_byte(8'($urandom_range(255)));
    r = $urandom_range(99);
    n = (r < 60) ? $urandom_range(6, 1) : (r < 85) ? $urandom_range(14, 7) : 15;
    for (int i = 0; i < n; i++) send_byte(rand_char());
    if (n == 15) begin
      send_byte(rand_char());
    end else begin
      r = $urandom_range(99);
      term = (r < 45) ? CH_CR : (r < 90) ? CH_LF : (r < 95) ? CH_NUL : CH_EOT;
      send_byte({1'($urandom_range(1)), term});
    end
  endtask

  initial begin
    logic [7:0] opening[$] = '{8'h41, 8'hc2, 8'h20, 8'h08, 8'h8d, 8'h08, 8'h7a, 8'h51,
                               8'h15, 8'h0a, 8'h80, 8'h84};
    bit         phase_parity[4] = '{1'b1, 1'b1, 1'b0, 1'b0};
    bit         phase_fast[4] = '{1'b1, 1'b0, 1'b0, 1'b1};
    int unsigned phase_send[4] = '{0, 69, 0, 20};
    int unsigned phase_recv[4] = '{0, 0, 69, 20};
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: folding, erase, kill, empty erase, restart, disconnect
    foreach (opening[i]) send_byte(opening[i]);
    // full store ends the line without a terminator
    for (int i = 0; i < 14; i++) send_byte(8'(8'h30 + i));
    send_byte(8'hff);
    send_byte(8'h78);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_cfg(phase_parity[p], phase_fast[p]);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      items_sent = 0;
      while (items_sent < LineItems) send_line();
      drain();
    end

    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
